### hdl/rlpe_pkg.sv
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants of the RGB LED pulse encoder: timing register
// group, queued command format and result status codes.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  // color word and bit segments per LED
  localparam int WORD_W    = 24;
  localparam int SEG_COUNT = 2 * WORD_W;
  localparam int SEG_W     = $clog2(SEG_COUNT);

  // timing register widths
  localparam int TICK_W  = 16;
  localparam int RESET_W = 24;
  localparam int DUR_W   = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // defaults
  localparam int LED_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_HIGH = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_BIT_LOW   = 2'd2,
    REG_RESET_LOW = 2'd3
  } reg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMING   = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  // what the back end does for one LED
  typedef enum logic [1:0] {
    KIND_BITS = 2'd0,
    KIND_ERR  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // timing registers
  typedef struct packed {
    logic [TICK_W-1:0]  zero_high;
    logic [TICK_W-1:0]  one_high;
    logic [TICK_W-1:0]  bit_low;
    logic [RESET_W-1:0] reset_low;
  } timing_t;

  // one classified LED request
  typedef struct packed {
    logic              pre_reset;
    kind_t             kind;
    logic              post_reset;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

### hdl/rlpe_front.sv
// ----------------------------------------------------------------------------
// rlpe_front
// Accepts LED requests, tracks frame state and LED count, and classifies each
// request into a command for the segment sequencer.
// ----------------------------------------------------------------------------
module rlpe_front #(
  parameter int LED_COUNT = rlpe_pkg::LED_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rlpe_pkg::WORD_W-1:0] in_tdata,
  input  logic                        in_tlast,
  input  rlpe_pkg::timing_t           timing,
  input  logic                        q_full,
  output logic                        q_push,
  output rlpe_pkg::cmd_t              q_cmd
);

  localparam int CNT_W = $clog2(LED_COUNT + 1);

  logic             frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_eff;
  logic             drop, timing_zero;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // classify the request against frame state
  always_comb begin
    count_eff   = frame_open_r ? count_r : '0;
    drop        = (count_eff >= CNT_W'(LED_COUNT));
    timing_zero = (timing.zero_high == '0) || (timing.one_high == '0) ||
                  (timing.bit_low == '0);
    q_cmd.pre_reset  = !frame_open_r;
    q_cmd.post_reset = in_tlast;
    q_cmd.word       = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    priority if (drop) begin
      q_cmd.kind = rlpe_pkg::KIND_DROP;
    end else if (timing_zero) begin
      q_cmd.kind = rlpe_pkg::KIND_ERR;
    end else begin
      q_cmd.kind = rlpe_pkg::KIND_BITS;
    end
  end

  // advance frame state on each accepted request
  always_comb begin
    frame_open_nxt = frame_open_r;
    count_nxt      = count_r;
    if (q_push) begin
      if (in_tlast) begin
        frame_open_nxt = 1'b0;
        count_nxt      = '0;
      end else begin
        frame_open_nxt = 1'b1;
        count_nxt      = drop ? count_eff : count_eff + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      count_r      <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

### hdl/rlpe_queue.sv
// ----------------------------------------------------------------------------
// rlpe_queue
// Short command queue between the front end and the segment sequencer.
// ----------------------------------------------------------------------------
module rlpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rlpe_pkg::cmd_t push_cmd,
  input  logic           pop,
  output rlpe_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = rlpe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlpe_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue popped while empty");
`endif

endmodule

### hdl/rlpe_back.sv
// ----------------------------------------------------------------------------
// rlpe_back
// Segment sequencer: plays out one queued command as reset, bit and status
// segments, one result per cycle into a registered output stage while the output is not stalled.
// ----------------------------------------------------------------------------
module rlpe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlpe_pkg::timing_t          timing,
  input  rlpe_pkg::cmd_t             q_head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_level,
  output logic [rlpe_pkg::DUR_W-1:0] out_dur,
  output rlpe_pkg::status_t          out_status,
  output logic                       out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PRE  = 4'b0010,
    S_BODY = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rlpe_pkg::SEG_W-1:0]   seg_r, seg_nxt;
  logic [rlpe_pkg::WORD_W-1:0]  word_r, word_nxt;
  rlpe_pkg::kind_t              kind_r, kind_nxt;
  logic                         post_r, post_nxt;

  logic                         out_valid_r;
  logic                         out_level_r, res_level;
  logic [rlpe_pkg::DUR_W-1:0]   out_dur_r, res_dur;
  rlpe_pkg::status_t            out_status_r, res_status;
  logic                         out_last_r, res_last;
  logic                         emit_ok, emit, body_done;

  assign emit_ok    = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_dur    = out_dur_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // sequence segments of the current command
  always_comb begin
    state_nxt  = state_r;
    seg_nxt    = seg_r;
    word_nxt   = word_r;
    kind_nxt   = kind_r;
    post_nxt   = post_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    res_level  = 1'b0;
    res_dur    = '0;
    res_status = rlpe_pkg::ST_OK;
    res_last   = 1'b0;
    body_done  = (kind_r != rlpe_pkg::KIND_BITS) ||
                 (seg_r == rlpe_pkg::SEG_W'(rlpe_pkg::SEG_COUNT - 1));
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          word_nxt  = q_head.word;
          kind_nxt  = q_head.kind;
          post_nxt  = q_head.post_reset;
          seg_nxt   = '0;
          state_nxt = q_head.pre_reset ? S_PRE : S_BODY;
        end
      end
      S_PRE: begin
        emit    = emit_ok;
        res_dur = rlpe_pkg::DUR_W'(timing.reset_low);
        if (emit_ok) begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        emit     = emit_ok;
        res_last = body_done && !post_r;
        unique case (kind_r)
          rlpe_pkg::KIND_DROP: res_status = rlpe_pkg::ST_DROPPED;
          rlpe_pkg::KIND_ERR:  res_status = rlpe_pkg::ST_TIMING;
          default: begin
            if (!seg_r[0]) begin
              res_level = 1'b1;
              res_dur   = rlpe_pkg::DUR_W'(word_r[rlpe_pkg::WORD_W-1] ?
                                            timing.one_high : timing.zero_high);
            end else begin
              res_dur = rlpe_pkg::DUR_W'(timing.bit_low);
            end
          end
        endcase
        if (emit_ok) begin
          seg_nxt = seg_r + rlpe_pkg::SEG_W'(1);
          if (seg_r[0]) begin
            word_nxt = {word_r[rlpe_pkg::WORD_W-2:0], 1'b0};
          end
          if (body_done) begin
            state_nxt = post_r ? S_POST : S_IDLE;
          end
        end
      end
      S_POST: begin
        emit     = emit_ok;
        res_dur  = rlpe_pkg::DUR_W'(timing.reset_low);
        res_last = 1'b1;
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold working command
  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    word_r <= word_nxt;
    kind_r <= kind_nxt;
    post_r <= post_nxt;
  end

  // output stage: load a result when the slot is free or being taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_level_r  <= res_level;
      out_dur_r    <= res_dur;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_ok) begin
        out_valid_r <= emit;
      end
    end
  end

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BODY) |-> (seg_r <= rlpe_pkg::SEG_W'(rlpe_pkg::SEG_COUNT - 1)))
    else $error("bit segment index past end of word");
`endif

endmodule

### hdl/rgb_led_pulse_encoder_core.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_core
// Addressable RGB LED pulse-width encoder: turns LED colors into timed line
// level segments (GRB, MSB first) with frame reset segments and status.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | request   | tdata: green, red, blue; tlast: frame_last
//  out_    | result    | tdata: line_level, duration_ticks; tuser: status;
//          |           | tlast: run_end
//  cfg_    | write     | cfg_index register index, cfg_data value
//
//  An LED plays out as 48 bit segments (one status segment if bit timing is
//  zero or the LED is dropped), plus one segment per frame reset; the segment
//  sequencer takes each command from the queue while idle.
//  A two-entry command queue lets the input take requests while segments play.
//  Reset (rst_n low, synchronous) closes the frame and loads default timing.
//  A stalled output holds its result; the sequencer waits for the slot.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder_core #(
  parameter int LED_COUNT = rlpe_pkg::LED_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // [7:0] green, [15:8] red, [23:16] blue
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlpe_pkg::WORD_W-1:0]      in_tdata,
  input  logic                             in_tlast,
  // [0] line_level, [24:1] duration_ticks, [31:25] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rlpe_pkg::timing_t          timing_r;
  rlpe_pkg::cmd_t             push_cmd, head;
  logic                       q_push, q_pop, q_full, q_empty;
  logic                       res_level;
  logic [rlpe_pkg::DUR_W-1:0] res_dur;
  rlpe_pkg::status_t          res_status;

  assign cfg_ready = 1'b1;

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.zero_high <= rlpe_pkg::TICK_W'(6);
      timing_r.one_high  <= rlpe_pkg::TICK_W'(16);
      timing_r.bit_low   <= rlpe_pkg::TICK_W'(16);
      timing_r.reset_low <= rlpe_pkg::RESET_W'(24000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (rlpe_pkg::reg_idx_t'(cfg_index))
        rlpe_pkg::REG_ZERO_HIGH: timing_r.zero_high <= cfg_data[rlpe_pkg::TICK_W-1:0];
        rlpe_pkg::REG_ONE_HIGH:  timing_r.one_high  <= cfg_data[rlpe_pkg::TICK_W-1:0];
        rlpe_pkg::REG_BIT_LOW:   timing_r.bit_low   <= cfg_data[rlpe_pkg::TICK_W-1:0];
        rlpe_pkg::REG_RESET_LOW: timing_r.reset_low <= cfg_data[rlpe_pkg::RESET_W-1:0];
        default: ;
      endcase
    end
  end

  rlpe_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .timing    (timing_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rlpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rlpe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing     (timing_r),
    .q_head     (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_level  (res_level),
    .out_dur    (res_dur),
    .out_status (res_status),
    .out_last   (out_tlast)
  );

  // pack result fields
  assign out_tdata = {7'd0, res_dur, res_level};
  assign out_tuser = res_status;

`ifndef SYNTHESIS
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != rlpe_pkg::ST_OK)) |->
      (out_tdata[24:1] == '0) && !out_tdata[0])
    else $error("status result carries a line segment");
`endif

endmodule
